### design/can_signal_decoder_with_health_core_defines.svh
// Assertion macros shared by the signal decoder with health block.
`ifndef CAN_SIGNAL_DECODER_WITH_HEALTH_CORE_DEFINES_SVH
`define CAN_SIGNAL_DECODER_WITH_HEALTH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CSDH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSDH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/csdh_pkg.sv
// Types and constants shared by the signal decoder with health block.
package csdh_pkg;

   localparam logic [3:0] KIND_RPM         = 4'd0;
   localparam logic [3:0] KIND_ENG_TEMP    = 4'd1;
   localparam logic [3:0] KIND_ENG_STAT    = 4'd2;
   localparam logic [3:0] KIND_BRAKE_STAT  = 4'd3;
   localparam logic [3:0] KIND_BRAKE_PRESS = 4'd4;
   localparam logic [3:0] KIND_SPEED       = 4'd5;
   localparam logic [3:0] KIND_BATT_STAT   = 4'd6;
   localparam logic [3:0] KIND_BATT_TEMP   = 4'd7;
   localparam logic [3:0] KIND_BATT_VOLT   = 4'd8;
   localparam logic [3:0] KIND_STEER_ANGLE = 4'd9;
   localparam logic [3:0] KIND_STEER_STAT  = 4'd10;
   localparam logic [3:0] KIND_OTHER       = 4'd11;

   localparam logic [1:0] HEALTH_OK    = 2'd0;
   localparam logic [1:0] HEALTH_WARN  = 2'd1;
   localparam logic [1:0] HEALTH_FAULT = 2'd2;

   localparam logic CSR_ECU_TIMEOUT = 1'b0;
   localparam logic CSR_STALE_LIMIT = 1'b1;

   localparam logic [15:0] ECU_TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] STALE_LIMIT_RESET = 16'd1000;

   localparam logic signed [16:0] LIM_ZERO       = 17'sd0;
   localparam logic signed [16:0] LIM_RPM_HI     = 17'sd9000;
   localparam logic signed [16:0] LIM_TEMP_LO    = -17'sd400;
   localparam logic signed [16:0] LIM_ENG_TEMP_HI = 17'sd2000;
   localparam logic signed [16:0] LIM_BRAKE_HI   = 17'sd2000;
   localparam logic signed [16:0] LIM_SPEED_HI   = 17'sd3000;
   localparam logic signed [16:0] LIM_PERCENT_HI = 17'sd100;
   localparam logic signed [16:0] LIM_PACK_TEMP_HI = 17'sd1000;
   localparam logic signed [16:0] LIM_VOLT_HI    = 17'sd5000;
   localparam logic signed [16:0] LIM_STEER_LO   = -17'sd5400;
   localparam logic signed [16:0] LIM_STEER_HI   = 17'sd5400;

   localparam logic [7:0] LOAD_MAX = 8'd100;

   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

   typedef struct packed {
      logic       mode;
      logic [3:0] message_kind;
      logic [2:0] sender_id;
      logic [7:0] data_byte0;
      logic [7:0] data_byte1;
      logic [7:0] data_byte2;
   } req_type;

   typedef struct packed {
      logic              tick;
      logic [3:0]        upd_kind;
      logic signed [14:0] prim;
      logic [6:0]        sec;
      logic              bad;
      logic [2:0]        src;
   } item_type;

   typedef struct packed {
      logic [15:0] ecu_timeout_ms;
      logic [15:0] stale_limit_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        health;
      logic              synchronized;
      logic              out_of_range;
      logic [3:0]        updated_kind;
      logic signed [14:0] primary_value;
      logic [6:0]        secondary_value;
      logic [31:0]       frames_seen;
      logic [31:0]       error_count;
      logic [7:0]        ecu_timeout_mask;
   } rsp_type;

endpackage

### design/csdh_front.sv
// Front end: classifies an item, decodes its signal and checks and clamps it.
module csdh_front (
   input  csdh_pkg::req_type  req,
   output csdh_pkg::item_type item
);
   import csdh_pkg::*;

   logic [15:0]        raw;
   logic               check;
   logic signed [16:0] val;
   logic signed [16:0] lo;
   logic signed [16:0] hi;
   logic signed [16:0] clamped;
   logic               below;
   logic               above;

   assign raw = {req.data_byte0, req.data_byte1};

   always_comb begin
      check = 1'b0;
      val = {1'b0, raw};
      lo = LIM_ZERO;
      hi = LIM_ZERO;
      item.tick = req.mode;
      item.upd_kind = KIND_OTHER;
      item.prim = '0;
      item.sec = '0;
      item.src = req.sender_id;
      if (!req.mode) begin
         case (req.message_kind)
            KIND_RPM: begin
               check = 1'b1;
               hi = LIM_RPM_HI;
               item.sec = (req.data_byte2 > LOAD_MAX) ? LOAD_MAX[6:0] : req.data_byte2[6:0];
               item.upd_kind = KIND_RPM;
            end
            KIND_ENG_TEMP: begin
               check = 1'b1;
               val = {raw[15], raw};
               lo = LIM_TEMP_LO;
               hi = LIM_ENG_TEMP_HI;
               item.upd_kind = KIND_ENG_TEMP;
            end
            KIND_ENG_STAT: begin
               item.upd_kind = KIND_ENG_STAT;
            end
            KIND_BRAKE_STAT: begin
               item.prim = 15'(req.data_byte0 == 8'd1);
               item.upd_kind = KIND_BRAKE_STAT;
            end
            KIND_BRAKE_PRESS: begin
               check = 1'b1;
               hi = LIM_BRAKE_HI;
               item.upd_kind = KIND_BRAKE_PRESS;
            end
            KIND_SPEED: begin
               check = 1'b1;
               hi = LIM_SPEED_HI;
               item.upd_kind = KIND_SPEED;
            end
            KIND_BATT_STAT: begin
               check = 1'b1;
               val = {9'd0, req.data_byte0};
               hi = LIM_PERCENT_HI;
               item.sec = 7'(req.data_byte1 == 8'd1);
               item.upd_kind = KIND_BATT_STAT;
            end
            KIND_BATT_TEMP: begin
               check = 1'b1;
               val = {raw[15], raw};
               lo = LIM_TEMP_LO;
               hi = LIM_PACK_TEMP_HI;
               item.upd_kind = KIND_BATT_TEMP;
            end
            KIND_BATT_VOLT: begin
               check = 1'b1;
               hi = LIM_VOLT_HI;
               item.upd_kind = KIND_BATT_VOLT;
            end
            KIND_STEER_ANGLE: begin
               check = 1'b1;
               val = {raw[15], raw};
               lo = LIM_STEER_LO;
               hi = LIM_STEER_HI;
               item.upd_kind = KIND_STEER_ANGLE;
            end
            KIND_STEER_STAT: begin
               item.upd_kind = KIND_STEER_STAT;
            end
            default: begin
               item.upd_kind = KIND_OTHER;
            end
         endcase
      end
      below = val < lo;
      above = val > hi;
      if (below) begin
         clamped = lo;
      end else if (above) begin
         clamped = hi;
      end else begin
         clamped = val;
      end
      item.bad = check && (below || above);
      if (check) begin
         item.prim = clamped[14:0];
      end
   end

endmodule

### design/csdh_queue.sv
// Short queue of classified items between the front and back ends.
module csdh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  csdh_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output csdh_pkg::item_type pop_item
);
   import csdh_pkg::*;

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff;
   logic [QUEUE_PTR_W:0]     count_in;
   logic                     push;
   logic                     pop;

   assign push_ready = count_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/csdh_back.sv
// Back end: updates counters and ECU ages, evaluates health and registers the result.
module csdh_back #(
   parameter int ECU_COUNT = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  csdh_pkg::cfg_type  cfg,
   input  logic               item_valid,
   output logic               item_ready,
   input  csdh_pkg::item_type item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output csdh_pkg::rsp_type  rsp
);
   import csdh_pkg::*;

   logic [ECU_COUNT-1:0] seen_ff;
   logic [ECU_COUNT-1:0] seen_in;
   logic [15:0]          age_ff [ECU_COUNT];
   logic [15:0]          age_in [ECU_COUNT];
   logic [15:0]          upd_age_ff;
   logic [15:0]          upd_age_in;
   logic [31:0]          frames_ff;
   logic [31:0]          frames_in;
   logic [31:0]          errors_ff;
   logic [31:0]          errors_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic [ECU_COUNT-1:0] timed_out;
   logic [7:0]           mask;
   logic                 pop;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop = item_valid && item_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      seen_in = seen_ff;
      upd_age_in = upd_age_ff;
      frames_in = frames_ff;
      errors_in = errors_ff;
      for (int e = 0; e < ECU_COUNT; e++) begin
         age_in[e] = age_ff[e];
      end
      if (pop) begin
         if (item.tick) begin
            upd_age_in = (upd_age_ff == 16'hFFFF) ? upd_age_ff : upd_age_ff + 16'd1;
            for (int e = 0; e < ECU_COUNT; e++) begin
               age_in[e] = (age_ff[e] == 16'hFFFF) ? age_ff[e] : age_ff[e] + 16'd1;
            end
         end else begin
            upd_age_in = '0;
            frames_in = (frames_ff == 32'hFFFF_FFFF) ? frames_ff : frames_ff + 32'd1;
            if (item.bad && errors_ff != 32'hFFFF_FFFF) begin
               errors_in = errors_ff + 32'd1;
            end
            for (int e = 0; e < ECU_COUNT; e++) begin
               if (32'(item.src) == e) begin
                  seen_in[e] = 1'b1;
                  age_in[e] = '0;
               end
            end
         end
      end
      for (int e = 0; e < ECU_COUNT; e++) begin
         timed_out[e] = seen_in[e] && (age_in[e] >= cfg.ecu_timeout_ms);
      end
   end

   for (genvar g = 0; g < 8; g++) begin : g_mask
      if (g < ECU_COUNT) begin : g_bit
         assign mask[g] = timed_out[g];
      end else begin : g_zero
         assign mask[g] = 1'b0;
      end
   end

   always_comb begin
      rsp_in.health = HEALTH_OK;
      if (timed_out != '0) begin
         rsp_in.health = HEALTH_FAULT;
      end else if (upd_age_in > cfg.stale_limit_ms) begin
         rsp_in.health = HEALTH_WARN;
      end
      rsp_in.synchronized = upd_age_in < cfg.stale_limit_ms;
      rsp_in.out_of_range = item.bad;
      rsp_in.updated_kind = item.upd_kind;
      rsp_in.primary_value = item.prim;
      rsp_in.secondary_value = item.sec;
      rsp_in.frames_seen = frames_in;
      rsp_in.error_count = errors_in;
      rsp_in.ecu_timeout_mask = mask;
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         upd_age_ff <= '0;
         frames_ff <= '0;
         errors_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < ECU_COUNT; e++) begin
            age_ff[e] <= '0;
         end
      end else begin
         seen_ff <= seen_in;
         upd_age_ff <= upd_age_in;
         frames_ff <= frames_in;
         errors_ff <= errors_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int e = 0; e < ECU_COUNT; e++) begin
            age_ff[e] <= age_in[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### design/can_signal_decoder_with_health_core.sv
// Each accepted request is stored in the queue, then its result is registered in the back end's output register.
// Throughput: one transaction per cycle while rsp_tready stays high; the back end's output register sets the pace.
// A two-entry queue lets the front keep accepting while a result waits to be taken.
// Reset clears the queue, counters, ECU ages and seen flags, and loads the timeout
// register with 500 and the stale limit register with 1000.
module can_signal_decoder_with_health_core #(
   parameter int ECU_COUNT = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sender_id[2:0], data_byte0[10:3], data_byte1[18:11], data_byte2[26:19]
   input  logic [31:0]  req_tdata,
   // mode[0], message_kind[4:1]
   input  logic [4:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // health[1:0], synchronized[2], out_of_range[3], primary_value[18:4],
   // secondary_value[25:19], frames_seen[57:26], error_count[89:58],
   // ecu_timeout_mask[97:90]
   output logic [103:0] rsp_tdata,
   // updated_kind[3:0]
   output logic [3:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);
   import csdh_pkg::*;
   `include "can_signal_decoder_with_health_core_defines.svh"

   req_type     req;
   item_type    front_item;
   item_type    back_item;
   logic        back_valid;
   logic        back_ready;
   rsp_type     rsp;
   cfg_type     cfg;
   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic [15:0] stale_ff;
   logic [15:0] stale_in;

   assign req.mode = req_tuser[0];
   assign req.message_kind = req_tuser[4:1];
   assign req.sender_id = req_tdata[2:0];
   assign req.data_byte0 = req_tdata[10:3];
   assign req.data_byte1 = req_tdata[18:11];
   assign req.data_byte2 = req_tdata[26:19];

   assign csr_ready = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      stale_in = stale_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ECU_TIMEOUT: timeout_in = csr_data;
            CSR_STALE_LIMIT: stale_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ECU_TIMEOUT_RESET;
         stale_ff <= STALE_LIMIT_RESET;
      end else begin
         timeout_ff <= timeout_in;
         stale_ff <= stale_in;
      end
   end

   assign cfg.ecu_timeout_ms = timeout_ff;
   assign cfg.stale_limit_ms = stale_ff;

   csdh_front u_front (
      .req  (req),
      .item (front_item)
   );

   csdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   csdh_back #(
      .ECU_COUNT (ECU_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.ecu_timeout_mask, rsp.error_count, rsp.frames_seen,
                       rsp.secondary_value, rsp.primary_value, rsp.out_of_range,
                       rsp.synchronized, rsp.health};
   assign rsp_tuser = rsp.updated_kind;

   `CSDH_ASSERT_IMP(a_health_code, clock, reset, rsp_tvalid,
      rsp.health == HEALTH_OK || rsp.health == HEALTH_WARN || rsp.health == HEALTH_FAULT,
      "health carries an undefined code")
   `CSDH_ASSERT_IMP(a_sync_not_warn, clock, reset, rsp_tvalid && rsp.synchronized,
      rsp.health != HEALTH_WARN, "synchronized result reports a stale warning")
   `CSDH_ASSERT_IMP(a_range_kind, clock, reset, rsp_tvalid && rsp.out_of_range,
      rsp.updated_kind != KIND_ENG_STAT && rsp.updated_kind != KIND_BRAKE_STAT &&
      rsp.updated_kind != KIND_STEER_STAT && rsp.updated_kind != KIND_OTHER,
      "range violation reported for a kind without limits")
   `CSDH_ASSERT_NXT(a_reset_empty, clock, reset, reset, !rsp_tvalid,
      "result valid right after reset")

endmodule

### test/tb.sv
// Self-checking testbench for the bus signal decoder with link health core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csdh_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PRESSURE_AT  = 300;
   localparam int PRESSURE_LEN = 300;
   localparam int PHASE_ITEMS  = 220;
   localparam int SETTLE       = 4;

   class health_scoreboard;
      logic [15:0] timeout_ms;
      logic [15:0] stale_ms;
      logic [6:0]  load_pct;
      logic        charging;
      logic [31:0] frame_cnt;
      logic [31:0] violation_cnt;
      logic [7:0]  seen;
      logic [15:0] ecu_age [8];
      logic [15:0] update_age;
      rsp_type     pending_status [$];
      int          mismatches;
      int          frames;
      int          ticks;
      int          violations;
      int          results;

      function new();
         timeout_ms = ECU_TIMEOUT_RESET;
         stale_ms = STALE_LIMIT_RESET;
         load_pct = '0;
         charging = 1'b0;
         frame_cnt = '0;
         violation_cnt = '0;
         seen = '0;
         foreach (ecu_age[k]) ecu_age[k] = '0;
         update_age = '0;
         mismatches = 0;
         frames = 0;
         ticks = 0;
         violations = 0;
         results = 0;
      endfunction

      function void set_config(logic idx, logic [15:0] value);
         if (idx == CSR_ECU_TIMEOUT) timeout_ms = value;
         else stale_ms = value;
      endfunction

      function int clip(int v, int lo, int hi, output bit bad);
         bad = (v < lo) || (v > hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 50) $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      endtask

      function void predict_status(req_type rq);
         rsp_type            st;
         logic signed [15:0] raw;
         int                 uval;
         int                 sval;
         int                 v;
         bit                 bad;
         bit                 fault;
         st = '0;
         st.updated_kind = KIND_OTHER;
         bad = 1'b0;
         fault = 1'b0;
         v = 0;
         raw = {rq.data_byte0, rq.data_byte1};
         uval = {16'd0, rq.data_byte0, rq.data_byte1};
         sval = raw;
         if (rq.mode) begin
            ticks++;
            if (update_age != 16'hFFFF) update_age++;
            foreach (ecu_age[e]) if (ecu_age[e] != 16'hFFFF) ecu_age[e]++;
         end else begin
            frames++;
            if (frame_cnt != 32'hFFFF_FFFF) frame_cnt++;
            seen[rq.sender_id] = 1'b1;
            ecu_age[rq.sender_id] = '0;
            update_age = '0;
            st.updated_kind = rq.message_kind;
            case (rq.message_kind)
               KIND_RPM: begin
                  v = clip(uval, LIM_ZERO, LIM_RPM_HI, bad);
                  load_pct = (rq.data_byte2 > LOAD_MAX) ? LOAD_MAX[6:0] : rq.data_byte2[6:0];
                  st.secondary_value = load_pct;
               end
               KIND_ENG_TEMP:    v = clip(sval, LIM_TEMP_LO, LIM_ENG_TEMP_HI, bad);
               KIND_BRAKE_STAT:  v = (rq.data_byte0 == 8'd1);
               KIND_BRAKE_PRESS: v = clip(uval, LIM_ZERO, LIM_BRAKE_HI, bad);
               KIND_SPEED:       v = clip(uval, LIM_ZERO, LIM_SPEED_HI, bad);
               KIND_BATT_STAT: begin
                  v = clip(int'(rq.data_byte0), LIM_ZERO, LIM_PERCENT_HI, bad);
                  charging = (rq.data_byte1 == 8'd1);
                  st.secondary_value = {6'd0, charging};
               end
               KIND_BATT_TEMP:   v = clip(sval, LIM_TEMP_LO, LIM_PACK_TEMP_HI, bad);
               KIND_BATT_VOLT:   v = clip(uval, LIM_ZERO, LIM_VOLT_HI, bad);
               KIND_STEER_ANGLE: v = clip(sval, LIM_STEER_LO, LIM_STEER_HI, bad);
               KIND_ENG_STAT, KIND_STEER_STAT: ;
               default:          st.updated_kind = KIND_OTHER;
            endcase
            st.primary_value = v[14:0];
            st.out_of_range = bad;
            if (bad) begin
               violations++;
               if (violation_cnt != 32'hFFFF_FFFF) violation_cnt++;
            end
         end
         foreach (ecu_age[e]) begin
            if (seen[e] && ecu_age[e] >= timeout_ms) begin
               fault = 1'b1;
               st.ecu_timeout_mask[e] = 1'b1;
            end
         end
         if (fault) st.health = HEALTH_FAULT;
         else if (update_age > stale_ms) st.health = HEALTH_WARN;
         else st.health = HEALTH_OK;
         st.synchronized = (update_age < stale_ms);
         st.frames_seen = frame_cnt;
         st.error_count = violation_cnt;
         pending_status.insert(pending_status.size(), st);
      endfunction

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results, name, got, want));
      endtask

      task check_status(rsp_type got);
         rsp_type want;
         results++;
         if (pending_status.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request waiting", results));
            return;
         end
         want = pending_status[0];
         pending_status.delete(0);
         check_field("health", got.health, want.health);
         check_field("synchronized", got.synchronized, want.synchronized);
         check_field("out_of_range", got.out_of_range, want.out_of_range);
         check_field("updated_kind", got.updated_kind, want.updated_kind);
         check_field("primary_value", got.primary_value, want.primary_value);
         check_field("secondary_value", got.secondary_value, want.secondary_value);
         check_field("frames_seen", got.frames_seen, want.frames_seen);
         check_field("error_count", got.error_count, want.error_count);
         check_field("ecu_timeout_mask", got.ecu_timeout_mask, want.ecu_timeout_mask);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic [4:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [15:0]  csr_data;

   health_scoreboard status_board = new();
   bit          steady;
   bit          pressure_done;
   int unsigned cycle_count;
   int          settings;

   can_signal_decoder_with_health_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("can_signal_decoder_with_health_core test failed");
      $finish;
   end

   initial begin
      rsp_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.health = rsp_tdata[1:0];
            got.synchronized = rsp_tdata[2];
            got.out_of_range = rsp_tdata[3];
            got.primary_value = rsp_tdata[18:4];
            got.secondary_value = rsp_tdata[25:19];
            got.frames_seen = rsp_tdata[57:26];
            got.error_count = rsp_tdata[89:58];
            got.ecu_timeout_mask = rsp_tdata[97:90];
            got.updated_kind = rsp_tuser;
            status_board.check_status(got);
         end
      end
   end

   initial begin
      int stall_left;
      int pick;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         pick = $urandom_range(0, 99);
         if (!pressure_done && status_board.results >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            stall_left = PRESSURE_LEN;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!steady && pick < 12) begin
            rsp_tready <= 1'b0;
            stall_left = (pick < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic mode, input logic [3:0] kind, input logic [2:0] src,
                            input logic [15:0] value, input logic [7:0] load);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      gap = (steady || pick < 75) ? 0 :
            ((pick < 97) ? $urandom_range(1, 3) : $urandom_range(15, 60));
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= {kind, mode};
      req_tdata <= {5'd0, load, value[7:0], value[15:8], src};
      do @(posedge clock); while (!req_tready);
      status_board.predict_status(req_type'{mode, kind, src, value[15:8], value[7:0], load});
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_board.pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_limits(input logic [15:0] timeout_ms, input logic [15:0] stale_ms);
      for (int i = 0; i < 2; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_ECU_TIMEOUT : CSR_STALE_LIMIT;
         csr_data <= (i == 0) ? timeout_ms : stale_ms;
         do @(posedge clock); while (!csr_ready);
         status_board.set_config((i == 0) ? CSR_ECU_TIMEOUT : CSR_STALE_LIMIT,
                                 (i == 0) ? timeout_ms : stale_ms);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic run_random(input int count);
      int          sent;
      int          burst;
      logic [3:0]  kind;
      logic [2:0]  src;
      logic [15:0] value;
      logic [7:0]  load;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 25) begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_item(1'b1, 4'($urandom), 3'($urandom), 16'($urandom),
                                     8'($urandom));
            sent += burst;
         end else begin
            kind = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                               : 4'($urandom_range(0, 11));
            case ($urandom_range(0, 3))
               0:       value = 16'($urandom);
               1:       value = 16'($urandom_range(0, 120));
               2:       value = 16'($urandom_range(0, 9100));
               default: value = 16'(0 - int'($urandom_range(0, 5600)));
            endcase
            if ($urandom_range(0, 1) == 1) begin
               if (kind == KIND_BRAKE_STAT) value[15:8] = 8'($urandom_range(0, 2));
               if (kind == KIND_BATT_STAT)
                  value = {8'($urandom_range(90, 110)), 8'($urandom_range(0, 2))};
            end
            src = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(0, 2))
                                               : 3'($urandom_range(0, 7));
            load = ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(90, 110));
            send_item(1'b0, kind, src, value, load);
            sent++;
         end
      end
   endtask

   initial begin
      int k;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ECU_TIMEOUT;
      csr_data = '0;
      steady = 1'b0;
      pressure_done = 1'b0;
      settings = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(1'b0, KIND_RPM, 3'd0, 16'd9000, 8'd100);
      send_item(1'b0, KIND_RPM, 3'd1, 16'd9001, 8'd101);
      send_item(1'b0, KIND_RPM, 3'd2, 16'hFFFF, 8'hFF);
      send_item(1'b0, KIND_RPM, 3'd3, 16'd0, 8'd0);
      send_item(1'b0, KIND_ENG_TEMP, 3'd4, 16'(-401), 8'd0);
      send_item(1'b0, KIND_ENG_TEMP, 3'd5, 16'd2001, 8'd0);
      send_item(1'b0, KIND_ENG_TEMP, 3'd6, 16'h8000, 8'd0);
      send_item(1'b0, KIND_ENG_STAT, 3'd7, 16'h1234, 8'd50);
      send_item(1'b0, KIND_BRAKE_STAT, 3'd0, 16'h0100, 8'd0);
      send_item(1'b0, KIND_BRAKE_STAT, 3'd1, 16'hFF01, 8'd0);
      send_item(1'b0, KIND_BRAKE_PRESS, 3'd2, 16'd2001, 8'd0);
      send_item(1'b0, KIND_SPEED, 3'd3, 16'd3001, 8'd0);
      send_item(1'b0, KIND_BATT_STAT, 3'd4, 16'h6401, 8'd0);
      send_item(1'b0, KIND_BATT_STAT, 3'd5, 16'hFFFF, 8'd0);
      send_item(1'b0, KIND_BATT_TEMP, 3'd6, 16'(-400), 8'd0);
      send_item(1'b0, KIND_BATT_TEMP, 3'd7, 16'd1001, 8'd0);
      send_item(1'b0, KIND_BATT_VOLT, 3'd0, 16'd5001, 8'd0);
      send_item(1'b0, KIND_STEER_ANGLE, 3'd1, 16'(-5401), 8'd0);
      send_item(1'b0, KIND_STEER_ANGLE, 3'd2, 16'd5400, 8'd0);
      send_item(1'b0, KIND_STEER_STAT, 3'd3, 16'h00FF, 8'd0);
      send_item(1'b0, KIND_OTHER, 3'd4, 16'h5555, 8'd0);
      send_item(1'b0, 4'hF, 3'd5, 16'hAAAA, 8'd0);
      send_item(1'b1, 4'hF, 3'd7, 16'hFFFF, 8'hFF);
      send_item(1'b1, KIND_RPM, 3'd0, 16'd0, 8'd0);
      drain();

      for (int p = 0; p < 7; p++) begin
         steady = (p == 1 || p == 4);
         case (p)
            0:       program_limits(16'd3, 16'd6);
            1:       program_limits(16'd0, 16'd0);
            2:       program_limits(16'hFFFF, 16'hFFFF);
            3:       program_limits(16'd1, 16'd1);
            6:       program_limits(16'($urandom), 16'($urandom));
            default: program_limits(16'($urandom_range(1, 40)), 16'($urandom_range(1, 60)));
         endcase
         run_random(PHASE_ITEMS);
         if (p < 6) drain();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      for (k = 0; k < 2000 && status_board.pending_status.size() != 0; k++) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (status_board.pending_status.size() != 0)
         status_board.report_mismatch($sformatf("%0d results never arrived",
                                                status_board.pending_status.size()));

      $display("Run covered %0d frames and %0d ticks under %0d limit settings,",
               status_board.frames, status_board.ticks, settings);
      $display("including zero and full-scale limits; %0d range violations were predicted.",
               status_board.violations);
      if (status_board.mismatches == 0) begin
         $display("can_signal_decoder_with_health_core test passed");
      end else begin
         $display("can_signal_decoder_with_health_core test failed");
      end
      $finish;
   end
endmodule

### files.f
+incdir+design
design/csdh_pkg.sv
design/csdh_front.sv
design/csdh_queue.sv
design/csdh_back.sv
design/can_signal_decoder_with_health_core.sv
test/tb.sv
